// ----- sv/tssv_pkg.sv -----
// Shared types, constants and helper functions for the terrain sample to sphere vertex block.
// No dependencies; every other file of the block imports this package.
package tssv_pkg;

    // Field widths fixed by the interface.
    localparam int ELEV_W   = 8;
    localparam int LON_W    = 10;
    localparam int COORD_W  = 17;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int TRIG_W   = 16;
    localparam int RADIUS_W = 25;
    localparam int ROM_W    = 2 * TRIG_W;

    // Elevation thresholds: at or below SEA_TOP is sea, up to SAND_TOP is sand.
    localparam logic [ELEV_W-1:0] SEA_TOP  = 8'd145;
    localparam logic [ELEV_W-1:0] SAND_TOP = 8'd148;

    // Unit radius in Q.24.
    localparam logic [RADIUS_W-1:0] ONE_Q24 = 25'h100_0000;

    // Quarter turn in Q30, used to build the longitude table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COS_LAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_LAT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_GAIN = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] COS_LAT_RESET   = 16'd0;
    localparam logic [CFG_W-1:0] SIN_LAT_RESET   = 16'd32767;
    localparam logic [CFG_W-1:0] LIFT_GAIN_RESET = 16'd12583;

    // Vertex color.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    // One longitude table entry, signed Q1.15.
    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_lon;
        logic signed [TRIG_W-1:0] cos_lon;
    } sincos_t;

    // Floor of v / 10 for v below 1024, by multiplying with the reciprocal.
    function automatic logic [6:0] div10(input logic [9:0] v);
        logic [22:0] prod;
        prod = {13'd0, v} * 23'd6554;
        return prod[22:16];
    endfunction

    // Color ramp for one elevation byte.
    function automatic color_t shade_color(input logic [ELEV_W-1:0] e);
        color_t     col;
        logic [7:0] depth;
        logic [7:0] sand_off;
        depth    = 8'd255 - e;
        sand_off = SAND_TOP - e;
        if (e > SAND_TOP)
        begin
            col.red   = 8'd25 + {1'b0, div10(10'({depth, 3'd0} - {2'd0, depth}))};
            col.green = {1'b0, div10(10'({depth, 2'd0} + {1'b0, depth, 1'b0}))};
            col.blue  = 8'd0;
        end
        else if (e > SEA_TOP)
        begin
            col.red   = 8'd115 + 8'(sand_off + {sand_off[6:0], 1'b0});
            col.green = 8'd85 + {sand_off[6:0], 1'b0};
            col.blue  = 8'd3;
        end
        else
        begin
            col.red   = 8'd1;
            col.green = 8'd1;
            col.blue  = 8'd32 + e;
        end
        return col;
    endfunction

endpackage

// ----- sv/tssv_rom.sv -----
// Longitude sine/cosine ROM with a registered read port, contents built at elaboration.
// Depends on tssv_pkg.
module tssv_rom #(
    parameter int STEPS_PER_TURN = 540
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [tssv_pkg::LON_W-1:0]    rd_addr,
    output tssv_pkg::sincos_t             rd_data
);
    import tssv_pkg::*;

    localparam int          ROM_DEPTH = 2 ** LON_W;
    localparam logic [63:0] STEPS_U64 = 64'(STEPS_PER_TURN);
    localparam logic [63:0] SIN_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
    localparam logic [63:0] COS_DIV [7] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182};

    // One entry: Taylor series in Q30 over the first quadrant, then quadrant symmetry.
    function automatic logic [ROM_W-1:0] rom_entry(input int unsigned idx);
        logic [63:0]        k;
        logic [63:0]        quad;
        logic [63:0]        m;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] ssum;
        logic signed [63:0] csum;
        logic [63:0]        rs;
        logic [63:0]        rc;
        logic [15:0]        s;
        logic [15:0]        c;
        logic [15:0]        s_out;
        logic [15:0]        c_out;
        int                 n;
        k    = 64'(idx) % STEPS_U64;
        quad = (k * 64'd4) / STEPS_U64;
        m    = (k * 64'd4) % STEPS_U64;
        x    = (HALF_PI_Q30 * m) / STEPS_U64;
        x2   = (x * x) >> 30;
        term = x;
        ssum = $signed(x);
        for (n = 0; n < 6; n++)
        begin
            term = ((term * x2) >> 30) / SIN_DIV[n];
            if (n % 2 == 0)
                ssum = ssum - $signed(term);
            else
                ssum = ssum + $signed(term);
        end
        term = 64'd1 << 30;
        csum = $signed(term);
        for (n = 0; n < 7; n++)
        begin
            term = ((term * x2) >> 30) / COS_DIV[n];
            if (n % 2 == 0)
                csum = csum - $signed(term);
            else
                csum = csum + $signed(term);
        end
        // Round half up to Q15 and clamp to 0..32767.
        if (ssum <= 0)
            s = 16'd0;
        else
        begin
            rs = ($unsigned(ssum) + 64'd16384) >> 15;
            s  = (rs > 64'd32767) ? 16'd32767 : rs[15:0];
        end
        if (csum <= 0)
            c = 16'd0;
        else
        begin
            rc = ($unsigned(csum) + 64'd16384) >> 15;
            c  = (rc > 64'd32767) ? 16'd32767 : rc[15:0];
        end
        case (quad[1:0])
            2'd0:
            begin
                s_out = s;
                c_out = c;
            end
            2'd1:
            begin
                s_out = c;
                c_out = -s;
            end
            2'd2:
            begin
                s_out = -s;
                c_out = -c;
            end
            default:
            begin
                s_out = -c;
                c_out = s;
            end
        endcase
        return {s_out, c_out};
    endfunction

    // Whole table; every index of the port wraps onto one turn.
    function automatic logic [ROM_DEPTH*ROM_W-1:0] rom_image();
        logic [ROM_DEPTH*ROM_W-1:0] img;
        int unsigned                i;
        img = '0;
        for (i = 0; i < ROM_DEPTH; i++)
            img[i*ROM_W +: ROM_W] = rom_entry(i);
        return img;
    endfunction

    localparam logic [ROM_DEPTH*ROM_W-1:0] ROM_IMAGE = rom_image();

    sincos_t rd_data_reg;

    // Registered read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= ROM_IMAGE[{rd_addr, 5'd0} +: ROM_W];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/tssv_shade.sv -----
// Color and radius stage: classifies the elevation and registers color and Q.24 radius.
// Depends on tssv_pkg.
module tssv_shade (
    input  logic                          clk,
    input  logic [tssv_pkg::ELEV_W-1:0]   elevation,
    input  logic [tssv_pkg::CFG_W-1:0]    lift_gain,
    output tssv_pkg::color_t              color,
    output logic [tssv_pkg::RADIUS_W-1:0] radius
);
    import tssv_pkg::*;

    color_t              color_reg;
    color_t              color_next;
    logic [RADIUS_W-1:0] radius_reg;
    logic [RADIUS_W-1:0] radius_next;
    logic [ELEV_W-1:0]   lift_steps;
    logic [23:0]         lift;

    // Radius is lifted only above sea level.
    always_comb
    begin
        color_next = shade_color(elevation);
        lift_steps = (elevation > SEA_TOP) ? elevation - SEA_TOP : '0;
        lift       = {16'd0, lift_steps} * {8'd0, lift_gain};
        radius_next = ONE_Q24 + {1'b0, lift};
    end

    always_ff @(posedge clk)
    begin
        color_reg  <= color_next;
        radius_reg <= radius_next;
    end

    assign color  = color_reg;
    assign radius = radius_reg;

endmodule

// ----- sv/tssv_project.sv -----
// Two-stage projection: latitude times longitude terms, then scaling by the radius.
// Depends on tssv_pkg.
module tssv_project (
    input  logic                                clk,
    input  tssv_pkg::sincos_t                   lon_trig,
    input  logic signed [tssv_pkg::CFG_W-1:0]   cos_lat,
    input  logic signed [tssv_pkg::CFG_W-1:0]   sin_lat,
    input  logic [tssv_pkg::RADIUS_W-1:0]       radius,
    output logic signed [tssv_pkg::COORD_W-1:0] pos_x,
    output logic signed [tssv_pkg::COORD_W-1:0] pos_y,
    output logic signed [tssv_pkg::COORD_W-1:0] pos_z
);
    import tssv_pkg::*;

    logic signed [31:0]        prod_x_reg;
    logic signed [31:0]        prod_z_reg;
    logic signed [31:0]        prod_x_next;
    logic signed [31:0]        prod_z_next;
    logic signed [COORD_W-1:0] pos_x_reg;
    logic signed [COORD_W-1:0] pos_y_reg;
    logic signed [COORD_W-1:0] pos_z_reg;
    logic signed [RADIUS_W:0]  radius_s;
    logic signed [57:0]        full_x;
    logic signed [57:0]        full_z;
    logic signed [41:0]        full_y;

    // First stage: cos(lat) times sin and cos of longitude, Q2.30.
    always_comb
    begin
        prod_x_next = cos_lat * lon_trig.sin_lon;
        prod_z_next = cos_lat * lon_trig.cos_lon;
    end

    // Second stage: scale by the radius; dropping low bits floors the result.
    always_comb
    begin
        radius_s = $signed({1'b0, radius});
        full_x   = prod_x_reg * radius_s;
        full_z   = prod_z_reg * radius_s;
        full_y   = sin_lat * radius_s;
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_z_reg <= prod_z_next;
        pos_x_reg  <= full_x[55:39];
        pos_y_reg  <= full_y[40:24];
        pos_z_reg  <= full_z[55:39];
    end

    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;

endmodule

// ----- sv/terrain_sample_to_sphere_vertex_top.sv -----
// Top level of the terrain sample to sphere vertex block: configuration registers and pipeline.
// Depends on tssv_pkg, tssv_rom, tssv_shade and tssv_project.

// The block accepts one transaction every clock cycle and never raises busy. Each result
// appears on the output ports with done high for one cycle. done travels through the valid
// flags v0_reg, v1_reg and done_reg in step with the data, and the result is taken at the
// rising edge while done is high. The three register stages are the registered longitude ROM
// read and the two multiplier stages of the projection. The receiver cannot stall the block,
// so results must be taken when done is high. Latitude and lift registers may only be written
// while no transaction is in flight.
module terrain_sample_to_sphere_vertex_top #(
    parameter int STEPS_PER_TURN = 540
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tssv_pkg::ELEV_W-1:0]         elevation,
    input  logic [tssv_pkg::LON_W-1:0]          lon_index,
    input  logic                                cfg_write,
    input  logic [tssv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tssv_pkg::CFG_W-1:0]          cfg_data,
    output logic                                done,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    output logic signed [tssv_pkg::COORD_W-1:0] pos_x,
    output logic signed [tssv_pkg::COORD_W-1:0] pos_y,
    output logic signed [tssv_pkg::COORD_W-1:0] pos_z
);
    import tssv_pkg::*;

    logic [CFG_W-1:0]    cos_lat_reg;
    logic [CFG_W-1:0]    sin_lat_reg;
    logic [CFG_W-1:0]    lift_gain_reg;
    logic                accept;
    logic                v0_reg;
    logic                v1_reg;
    logic                done_reg;
    logic [ELEV_W-1:0]   elev_reg;
    sincos_t             lon_trig;
    color_t              color_s1;
    color_t              color_reg;
    logic [RADIUS_W-1:0] radius_s1;

    assign accept = start & ~busy;
    assign busy   = 1'b0;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_lat_reg   <= COS_LAT_RESET;
            sin_lat_reg   <= SIN_LAT_RESET;
            lift_gain_reg <= LIFT_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COS_LAT:   cos_lat_reg   <= cfg_data;
                CFG_SIN_LAT:   sin_lat_reg   <= cfg_data;
                CFG_LIFT_GAIN: lift_gain_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= accept;
            v1_reg   <= v0_reg;
            done_reg <= v1_reg;
        end
    end

    // Input capture alongside the ROM read, and color alignment with the projection.
    always_ff @(posedge clk)
    begin
        if (accept)
            elev_reg <= elevation;
        color_reg <= color_s1;
    end

    tssv_rom #(
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_rom (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (lon_index),
        .rd_data (lon_trig)
    );

    tssv_shade u_shade (
        .clk       (clk),
        .elevation (elev_reg),
        .lift_gain (lift_gain_reg),
        .color     (color_s1),
        .radius    (radius_s1)
    );

    tssv_project u_project (
        .clk      (clk),
        .lon_trig (lon_trig),
        .cos_lat  ($signed(cos_lat_reg)),
        .sin_lat  ($signed(sin_lat_reg)),
        .radius   (radius_s1),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z)
    );

    assign done  = done_reg;
    assign red   = color_reg.red;
    assign green = color_reg.green;
    assign blue  = color_reg.blue;

endmodule

// ----- sv/tssv_checker.sv -----
// Port-level assertions for the terrain sample to sphere vertex block, bound to the top level.
// Depends on tssv_pkg and terrain_sample_to_sphere_vertex_top.
module tssv_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [tssv_pkg::ELEV_W-1:0]         elevation,
    input logic                                done,
    input logic [7:0]                          red,
    input logic [7:0]                          green,
    input logic [7:0]                          blue
);
    import tssv_pkg::*;

    // Every accepted transaction yields a result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted transaction produced no result");

    // No result without a matching accepted transaction.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without a matching transaction");

    // Sea samples get the fixed red and green and a blue that follows the elevation.
    a_sea_color: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(elevation <= SEA_TOP, 3)) |->
        (red == 8'd1 && green == 8'd1 && blue == 8'd32 + $past(elevation, 3)))
        else $error("wrong sea color");

    // Land samples carry no blue.
    a_land_blue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(elevation > SAND_TOP, 3)) |-> (blue == 8'd0))
        else $error("land sample with nonzero blue");

endmodule

bind terrain_sample_to_sphere_vertex_top tssv_checker u_tssv_checker (.*);
